FILE: hdl/sample_select_command_parser_assert.svh
// assertion macros for the command parser back end
`ifndef SAMPLE_SELECT_COMMAND_PARSER_ASSERT_SVH
`define SAMPLE_SELECT_COMMAND_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sscp assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SSCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sscp assertion failed");

`endif

FILE: hdl/sscp_pkg.sv
// package with beat types, character classes and result codes
`timescale 1ns / 1ps
package sscp_pkg;

  localparam logic [2:0] KIND_ANALOG  = 3'd0;
  localparam logic [2:0] KIND_DIGITAL = 3'd1;
  localparam logic [2:0] KIND_UNKNOWN = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  localparam logic [2:0] ERR_BRACE  = 3'd0;
  localparam logic [2:0] ERR_QUOTE  = 3'd1;
  localparam logic [2:0] ERR_CLOSEQ = 3'd2;
  localparam logic [2:0] ERR_COLON  = 3'd3;
  localparam logic [2:0] ERR_VALUE  = 3'd4;
  localparam logic [2:0] ERR_SEP    = 3'd5;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] key_type;
    logic [7:0] key_ident;
    logic [2:0] error_code;
  } out_beat_t;

  typedef struct packed {
    logic is_ws;
    logic is_nul;
    logic is_lbrace;
    logic is_rbrace;
    logic is_quote;
    logic is_colon;
    logic is_comma;
    logic is_zero;
    logic is_one;
  } cls_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    cls_t       cls;
  } q_entry_t;

endpackage

FILE: hdl/sample_select_command_parser.sv
// top level of the sample-select command parser
//
//   channel  direction  beat                      handshake
//   in_      input      ch[7:0], first            in_valid / in_ready
//   out_     output     kind, key_type, key_ident out_valid / out_ready
//                       error_code
//
// one character per cycle sustained while no result waits on out_ready; a result
// is on out_ after its character is taken, through a queue entry and then the result register
// the two-entry queue decouples intake from the parser state machine
// in_ready falls only when the queue is full, which needs out_ready low
// synchronous active-low reset empties the queue and idles the parser
`timescale 1ns / 1ps
module sample_select_command_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sscp_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sscp_pkg::out_beat_t out_data
);

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  sscp_pkg::q_entry_t q_wdata;
  sscp_pkg::q_entry_t q_rdata;

  sscp_front u_front (
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  sscp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  sscp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/sscp_front.sv
// front end: input handshake and character classification
`timescale 1ns / 1ps
module sscp_front (
  input  sscp_pkg::in_beat_t in_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               q_full,
  output logic               q_push,
  output sscp_pkg::q_entry_t q_wdata
);

  sscp_pkg::cls_t cls;

  always_comb begin
    cls.is_ws     = ((in_data.ch >= sscp_pkg::CH_TAB) && (in_data.ch <= sscp_pkg::CH_CR)) ||
                    (in_data.ch == sscp_pkg::CH_SPACE);
    cls.is_nul    = (in_data.ch == sscp_pkg::CH_NUL);
    cls.is_lbrace = (in_data.ch == sscp_pkg::CH_LBRACE);
    cls.is_rbrace = (in_data.ch == sscp_pkg::CH_RBRACE);
    cls.is_quote  = (in_data.ch == sscp_pkg::CH_QUOTE);
    cls.is_colon  = (in_data.ch == sscp_pkg::CH_COLON);
    cls.is_comma  = (in_data.ch == sscp_pkg::CH_COMMA);
    cls.is_zero   = (in_data.ch == sscp_pkg::CH_ZERO);
    cls.is_one    = (in_data.ch == sscp_pkg::CH_ONE);
  end

  assign in_ready      = !q_full;
  assign q_push        = in_valid && !q_full;
  assign q_wdata.ch    = in_data.ch;
  assign q_wdata.first = in_data.first;
  assign q_wdata.cls   = cls;

endmodule

FILE: hdl/sscp_queue.sv
// two-entry queue between front and back end
`timescale 1ns / 1ps
module sscp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sscp_pkg::q_entry_t wdata,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output sscp_pkg::q_entry_t rdata
);

  localparam int PtrW = $clog2(sscp_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(sscp_pkg::QUEUE_DEPTH + 1);

  sscp_pkg::q_entry_t mem_r [sscp_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]    wr_ptr_r;
  logic [PtrW-1:0]    rd_ptr_r;
  logic [CntW-1:0]    count_r;
  logic [CntW-1:0]    count_nxt;

  assign full  = (count_r == CntW'(sscp_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(sscp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(sscp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: hdl/sscp_back.sv
// back end: parser state machine and result register
`timescale 1ns / 1ps
`include "sample_select_command_parser_assert.svh"
module sscp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  sscp_pkg::q_entry_t  q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output sscp_pkg::out_beat_t out_data
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_BRACE  = 4'd1;
  localparam logic [3:0] PH_TOP    = 4'd2;
  localparam logic [3:0] PH_WS     = 4'd3;
  localparam logic [3:0] PH_TYPE   = 4'd4;
  localparam logic [3:0] PH_IDENT  = 4'd5;
  localparam logic [3:0] PH_CLOSEQ = 4'd6;
  localparam logic [3:0] PH_COLON  = 4'd7;
  localparam logic [3:0] PH_VALUE  = 4'd8;
  localparam logic [3:0] PH_AFTER  = 4'd9;

  logic [3:0]          phase_r;
  logic [3:0]          phase_nxt;
  logic [3:0]          ph_cur;
  logic [7:0]          held_type_r;
  logic [7:0]          held_type_nxt;
  logic [7:0]          held_ident_r;
  logic [7:0]          held_ident_nxt;
  logic [7:0]          type_cur;
  logic [7:0]          ident_cur;
  logic                res_valid;
  sscp_pkg::out_beat_t res;
  logic                out_valid_r;
  sscp_pkg::out_beat_t out_data_r;
  sscp_pkg::cls_t      c;
  logic                take;

  assign take      = !q_empty && (!out_valid_r || out_ready);
  assign q_pop     = take;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign c         = q_rdata.cls;

  always_comb begin
    ph_cur         = q_rdata.first ? PH_BRACE : phase_r;
    type_cur       = q_rdata.first ? 8'd0 : held_type_r;
    ident_cur      = q_rdata.first ? 8'd0 : held_ident_r;
    phase_nxt      = ph_cur;
    held_type_nxt  = type_cur;
    held_ident_nxt = ident_cur;
    res_valid      = 1'b0;
    res            = '0;
    unique case (ph_cur)
      PH_BRACE: begin
        if (!c.is_lbrace) begin
          res_valid      = 1'b1;
          res.kind       = sscp_pkg::KIND_ERROR;
          res.error_code = sscp_pkg::ERR_BRACE;
        end else begin
          phase_nxt = PH_TOP;
        end
      end
      PH_TOP: begin
        if (c.is_rbrace || c.is_nul) begin
          res_valid = 1'b1;
          res.kind  = sscp_pkg::KIND_DONE;
        end else if (c.is_ws) begin
          phase_nxt = PH_WS;
        end else if (!c.is_quote) begin
          res_valid      = 1'b1;
          res.kind       = sscp_pkg::KIND_ERROR;
          res.error_code = sscp_pkg::ERR_QUOTE;
        end else begin
          phase_nxt = PH_TYPE;
        end
      end
      PH_WS: begin
        if (c.is_ws) begin
          phase_nxt = PH_WS;
        end else if (c.is_nul) begin
          res_valid = 1'b1;
          res.kind  = sscp_pkg::KIND_DONE;
        end else if (!c.is_quote) begin
          res_valid      = 1'b1;
          res.kind       = sscp_pkg::KIND_ERROR;
          res.error_code = sscp_pkg::ERR_QUOTE;
        end else begin
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (c.is_nul) begin
          res_valid      = 1'b1;
          res.kind       = sscp_pkg::KIND_ERROR;
          res.error_code = sscp_pkg::ERR_CLOSEQ;
        end else begin
          held_type_nxt = q_rdata.ch;
          phase_nxt     = PH_IDENT;
        end
      end
      PH_IDENT: begin
        if (c.is_nul) begin
          res_valid      = 1'b1;
          res.kind       = sscp_pkg::KIND_ERROR;
          res.error_code = sscp_pkg::ERR_CLOSEQ;
        end else begin
          held_ident_nxt = q_rdata.ch;
          phase_nxt      = PH_CLOSEQ;
        end
      end
      PH_CLOSEQ: begin
        if (!c.is_quote) begin
          res_valid      = 1'b1;
          res.kind       = sscp_pkg::KIND_ERROR;
          res.error_code = sscp_pkg::ERR_CLOSEQ;
        end else begin
          phase_nxt = PH_COLON;
        end
      end
      PH_COLON: begin
        if (!c.is_colon) begin
          res_valid      = 1'b1;
          res.kind       = sscp_pkg::KIND_ERROR;
          res.error_code = sscp_pkg::ERR_COLON;
        end else begin
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (c.is_ws) begin
          phase_nxt = PH_VALUE;
        end else if (c.is_zero) begin
          phase_nxt = PH_AFTER;
        end else if (c.is_one) begin
          res_valid     = 1'b1;
          res.key_type  = type_cur;
          res.key_ident = ident_cur;
          if (type_cur == sscp_pkg::CH_A) begin
            res.kind = sscp_pkg::KIND_ANALOG;
          end else if (type_cur == sscp_pkg::CH_D) begin
            res.kind = sscp_pkg::KIND_DIGITAL;
          end else begin
            res.kind = sscp_pkg::KIND_UNKNOWN;
          end
          phase_nxt = PH_AFTER;
        end else begin
          res_valid      = 1'b1;
          res.kind       = sscp_pkg::KIND_ERROR;
          res.error_code = sscp_pkg::ERR_VALUE;
        end
      end
      PH_AFTER: begin
        if (c.is_ws) begin
          phase_nxt = PH_AFTER;
        end else if (c.is_comma) begin
          phase_nxt = PH_TOP;
        end else if (c.is_rbrace) begin
          res_valid = 1'b1;
          res.kind  = sscp_pkg::KIND_DONE;
        end else begin
          res_valid      = 1'b1;
          res.kind       = sscp_pkg::KIND_ERROR;
          res.error_code = sscp_pkg::ERR_SEP;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    // done and error both end the command
    if (res_valid && ((res.kind == sscp_pkg::KIND_DONE) || (res.kind == sscp_pkg::KIND_ERROR))) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      held_type_r  <= '0;
      held_ident_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        phase_r      <= phase_nxt;
        held_type_r  <= held_type_nxt;
        held_ident_r <= held_ident_nxt;
      end
      if (take && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_data_r <= res;
    end
  end

  `SSCP_ASSERT_NEXT(a_end_goes_idle, take && res_valid && ((res.kind == sscp_pkg::KIND_DONE) || (res.kind == sscp_pkg::KIND_ERROR)), phase_r == PH_IDLE)
  `SSCP_ASSERT_NOW(a_idle_silent, take && (phase_r == PH_IDLE) && !q_rdata.first, !res_valid)
  `SSCP_ASSERT_NOW(a_end_no_key, out_valid_r && ((out_data_r.kind == sscp_pkg::KIND_DONE) || (out_data_r.kind == sscp_pkg::KIND_ERROR)), (out_data_r.key_type == 8'd0) && (out_data_r.key_ident == 8'd0))
  `SSCP_ASSERT_NEXT(a_result_loaded, take && res_valid, out_valid_r && (out_data_r == $past(res)))

endmodule

FILE: tb/tb_sample_select_command_parser.sv
// testbench for the sample-select command parser: directed and random commands against a predictor
`timescale 1ns / 1ps
module tb_sample_select_command_parser;
  import sscp_pkg::*;

  typedef enum logic [3:0] {
    PS_IDLE, PS_BRACE, PS_TOP, PS_WS, PS_TYPE, PS_IDENT,
    PS_CLOSEQ, PS_COLON, PS_VALUE, PS_AFTER
  } parse_state_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  parse_state_t pstate = PS_IDLE;
  logic [7:0]   key_type_held = '0;
  logic [7:0]   key_ident_held = '0;
  out_beat_t    expected_results[$];
  int           fail_count = 0;
  int           active_chars = 0;
  int           send_idle_pct = 35;
  int           recv_idle_pct = 87;

  sample_select_command_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("sample_select_command_parser regression: fail");
    $finish;
  end

  function automatic bit is_blank(input logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == CH_SPACE;
  endfunction

  // advances the parser state by one character, returns 1 when a result is due
  function automatic bit parse_char(input in_beat_t b, output out_beat_t r);
    logic [7:0] c;
    bit         ends;
    bit         has;
    c = b.ch;
    r = '0;
    ends = 1'b0;
    has = 1'b0;
    if (b.first) begin
      pstate = PS_BRACE;
      key_type_held = '0;
      key_ident_held = '0;
    end
    case (pstate)
      PS_BRACE: begin
        if (c != CH_LBRACE) begin
          r.kind = KIND_ERROR; r.error_code = ERR_BRACE; ends = 1'b1;
        end else pstate = PS_TOP;
      end
      PS_TOP: begin
        if (c == CH_RBRACE || c == CH_NUL) begin
          r.kind = KIND_DONE; ends = 1'b1;
        end else if (is_blank(c)) pstate = PS_WS;
        else if (c != CH_QUOTE) begin
          r.kind = KIND_ERROR; r.error_code = ERR_QUOTE; ends = 1'b1;
        end else pstate = PS_TYPE;
      end
      PS_WS: begin
        if (is_blank(c)) pstate = PS_WS;
        else if (c == CH_NUL) begin
          r.kind = KIND_DONE; ends = 1'b1;
        end else if (c != CH_QUOTE) begin
          r.kind = KIND_ERROR; r.error_code = ERR_QUOTE; ends = 1'b1;
        end else pstate = PS_TYPE;
      end
      PS_TYPE: begin
        if (c == CH_NUL) begin
          r.kind = KIND_ERROR; r.error_code = ERR_CLOSEQ; ends = 1'b1;
        end else begin
          key_type_held = c; pstate = PS_IDENT;
        end
      end
      PS_IDENT: begin
        if (c == CH_NUL) begin
          r.kind = KIND_ERROR; r.error_code = ERR_CLOSEQ; ends = 1'b1;
        end else begin
          key_ident_held = c; pstate = PS_CLOSEQ;
        end
      end
      PS_CLOSEQ: begin
        if (c != CH_QUOTE) begin
          r.kind = KIND_ERROR; r.error_code = ERR_CLOSEQ; ends = 1'b1;
        end else pstate = PS_COLON;
      end
      PS_COLON: begin
        if (c != CH_COLON) begin
          r.kind = KIND_ERROR; r.error_code = ERR_COLON; ends = 1'b1;
        end else pstate = PS_VALUE;
      end
      PS_VALUE: begin
        if (is_blank(c)) pstate = PS_VALUE;
        else if (c == CH_ZERO) pstate = PS_AFTER;
        else if (c == CH_ONE) begin
          if (key_type_held == CH_A) r.kind = KIND_ANALOG;
          else if (key_type_held == CH_D) r.kind = KIND_DIGITAL;
          else r.kind = KIND_UNKNOWN;
          r.key_type = key_type_held;
          r.key_ident = key_ident_held;
          has = 1'b1;
          pstate = PS_AFTER;
        end else begin
          r.kind = KIND_ERROR; r.error_code = ERR_VALUE; ends = 1'b1;
        end
      end
      PS_AFTER: begin
        if (is_blank(c)) pstate = PS_AFTER;
        else if (c == CH_COMMA) pstate = PS_TOP;
        else if (c == CH_RBRACE) begin
          r.kind = KIND_DONE; ends = 1'b1;
        end else begin
          r.kind = KIND_ERROR; r.error_code = ERR_SEP; ends = 1'b1;
        end
      end
      default: pstate = PS_IDLE;
    endcase
    if (ends) pstate = PS_IDLE;
    return has || ends;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic send_char(input logic [7:0] c, input logic f);
    in_beat_t  beat;
    out_beat_t r;
    beat.ch = c;
    beat.first = f;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (f || pstate != PS_IDLE) active_chars++;
    if (parse_char(beat, r)) expected_results.push_back(r);
  endtask

  task automatic send_text(input string s, input bit first_flag);
    for (int i = 0; i < s.len(); i++) send_char(s[i], first_flag && i == 0);
  endtask

  function automatic logic [7:0] random_ws();
    int pick;
    pick = $urandom_range(0, 5);
    return pick == 5 ? CH_SPACE : CH_TAB + 8'(pick);
  endfunction

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = expected_results.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_data.kind, want.kind));
        if (out_data.key_type !== want.key_type)
          report_mismatch($sformatf("key_type %h, want %h", out_data.key_type, want.key_type));
        if (out_data.key_ident !== want.key_ident)
          report_mismatch($sformatf("key_ident %h, want %h", out_data.key_ident,
                                    want.key_ident));
        if (out_data.error_code !== want.error_code)
          report_mismatch($sformatf("error_code %0d, want %0d", out_data.error_code,
                                    want.error_code));
      end
    end
  end

  task automatic test_framing();
    send_char("x", 1'b0);
    send_char(CH_SPACE, 1'b1);
    send_text("{}", 1'b1);
    send_char("}", 1'b0);
    send_text("{ }", 1'b1);
    send_char(CH_LBRACE, 1'b1);
    send_char(CH_NUL, 1'b0);
    send_char(CH_LBRACE, 1'b1);
    send_char(CH_TAB, 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(CH_NUL, 1'b0);
  endtask

  task automatic test_selections();
    send_text("{\"A1\":1,\"D9\": 1 , \"Zq\":\t1,\"A2\":0}", 1'b1);
    send_text("{\"D", 1'b1);
    send_char(8'hFF, 1'b0);
    send_text("\":1}", 1'b0);
  endtask

  task automatic test_format_errors();
    send_text("{x", 1'b1);
    send_text("{\"", 1'b1);
    send_char(CH_NUL, 1'b0);
    send_text("{\"A", 1'b1);
    send_char(CH_NUL, 1'b0);
    send_text("{\"ABx", 1'b1);
    send_text("{\"AB\"x", 1'b1);
    send_text("{\"AB\":x", 1'b1);
    send_text("{\"AB\":1x", 1'b1);
    send_text("{\"AB\":0", 1'b1);
    send_char(CH_NUL, 1'b0);
    send_text("{\"A", 1'b1);
    send_text("{}", 1'b1);
  endtask

  task automatic test_random_commands(input int budget);
    logic [7:0] cmd[$];
    int         stop_at;
    int         keys;
    int         pick;
    stop_at = active_chars + budget;
    while (active_chars < stop_at) begin
      cmd = {CH_LBRACE};
      keys = $urandom_range(0, 4);
      for (int k = 0; k < keys; k++) begin
        if (k > 0) cmd.push_back(CH_COMMA);
        if ($urandom_range(0, 3) == 0) cmd.push_back(random_ws());
        cmd.push_back(CH_QUOTE);
        pick = $urandom_range(0, 9);
        cmd.push_back(pick < 4 ? CH_A : pick < 8 ? CH_D : 8'($urandom_range(1, 255)));
        cmd.push_back(8'($urandom_range(1, 255)));
        cmd.push_back(CH_QUOTE);
        cmd.push_back(CH_COLON);
        if ($urandom_range(0, 3) == 0) cmd.push_back(random_ws());
        cmd.push_back($urandom_range(0, 4) < 3 ? CH_ONE : CH_ZERO);
        if ($urandom_range(0, 3) == 0) cmd.push_back(random_ws());
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        cmd.push_back(CH_RBRACE);
      end else begin
        if (keys > 0) cmd.push_back(CH_COMMA);
        if (pick >= 8) cmd.push_back(random_ws());
        cmd.push_back(CH_NUL);
      end
      // damage some commands: a stray byte or an early cut
      pick = $urandom_range(0, 99);
      if (pick < 15) cmd[$urandom_range(0, cmd.size() - 1)] = 8'($urandom_range(0, 255));
      else if (pick < 25) cmd = cmd[0:$urandom_range(0, cmd.size() - 1)];
      foreach (cmd[i]) send_char(cmd[i], i == 0);
      if ($urandom_range(0, 3) == 0) send_char(8'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 19) == 0) send_char(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_framing();
    test_selections();
    test_format_errors();
    test_random_commands(230);
    send_idle_pct = 87;
    recv_idle_pct = 35;
    test_random_commands(230);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_commands(230);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (fail_count == 0) begin
      $display("sample_select_command_parser regression: pass");
    end else begin
      $display("sample_select_command_parser regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/sscp_pkg.sv
hdl/sscp_front.sv
hdl/sscp_queue.sv
hdl/sscp_back.sv
hdl/sample_select_command_parser.sv
tb/tb_sample_select_command_parser.sv
